// ----- rtl/gccs_pkg.sv -----
`default_nettype none
package gccs_pkg;

  localparam int NUM_DENOMS_DEF = 6;
  localparam int DENOM_REGS     = 6;
  localparam int VAL_W          = 16;
  localparam int SLOT_W         = 3;
  localparam int OP_W           = 2;
  localparam int ST_W           = 2;
  localparam int CFG_AW         = 5;
  localparam int CFG_DW         = 32;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 24;

  localparam logic [VAL_W-1:0] RESTOCK_STEP = 16'd10;

  // reset denominations, entry 0 in the lowest bits
  localparam logic [DENOM_REGS-1:0][VAL_W-1:0] DENOM_RST = {
    16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200
  };

  typedef enum logic [OP_W-1:0] {
    OP_CHANGE  = 2'd0,
    OP_RESTOCK = 2'd1,
    OP_SET     = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_EXACT    = 2'd0,
    ST_NO_STOCK = 2'd1,
    ST_NO_EXACT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_USE_STOCK  = 3'd0,
    REG_NUM_DENOMS = 3'd1,
    REG_DENOM_0    = 3'd2,
    REG_DENOM_1    = 3'd3,
    REG_DENOM_2    = 3'd4,
    REG_DENOM_3    = 3'd5,
    REG_DENOM_4    = 3'd6,
    REG_DENOM_5    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_CHECK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic restock;
    logic set_stock;
    logic skip;
    logic div_start;
    logic div_step;
    logic check;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic denom_zero;
    logic div_last;
    logic over_stock;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/gccs_ctrl.sv -----
`default_nettype none
module gccs_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_valid_i,
  input  wire gccs_pkg::opcode_e opcode_i,
  output logic                s_ready_o,
  input  wire gccs_pkg::stat_t   stat_i,
  output gccs_pkg::cmd_t      cmd_o
);
  import gccs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          unique case (opcode_i)
            OP_CHANGE: begin
              cmd_o.start = 1'b1;
              state_d     = S_WALK;
            end
            OP_RESTOCK: cmd_o.restock   = 1'b1;
            OP_SET:     cmd_o.set_stock = 1'b1;
            OP_NONE:    ;
            default:    ;
          endcase
        end
      end
      S_WALK: begin
        priority if (stat_i.walk_done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_EMIT;
        end else if (stat_i.denom_zero) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.over_stock ? S_EMIT : S_WALK;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/gccs_dp.sv -----
`default_nettype none
module gccs_dp #(
  parameter int NUM_DENOMS = gccs_pkg::NUM_DENOMS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         use_stock_i,
  input  wire logic [gccs_pkg::SLOT_W-1:0]                  n_i,
  input  wire logic [NUM_DENOMS-1:0][gccs_pkg::VAL_W-1:0]   denoms_i,
  input  wire logic [gccs_pkg::VAL_W-1:0]                   amount_i,
  input  wire logic [gccs_pkg::SLOT_W-1:0]                  sel_i,
  input  wire logic [gccs_pkg::VAL_W-1:0]                   sval_i,
  input  wire gccs_pkg::cmd_t                               cmd_i,
  output gccs_pkg::stat_t                                   stat_o,
  output logic                                              m_valid_o,
  input  wire logic                                         m_ready_i,
  output logic [gccs_pkg::SLOT_W-1:0]                       m_slot_o,
  output logic [gccs_pkg::VAL_W-1:0]                        m_count_o,
  output logic [gccs_pkg::ST_W-1:0]                         m_status_o,
  output logic                                              m_last_o
);
  import gccs_pkg::*;

  localparam int CW   = $clog2(NUM_DENOMS + 1);
  localparam int IW   = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
  localparam int DCW  = $clog2(VAL_W);
  localparam logic [SLOT_W-1:0] NMAX = SLOT_W'(NUM_DENOMS);

  logic [VAL_W-1:0]  stock_q [NUM_DENOMS];
  logic [VAL_W-1:0]  counts_q [NUM_DENOMS];
  logic [CW-1:0]     idx_q;
  logic [IW-1:0]     ix;
  logic [VAL_W-1:0]  rem_q;
  logic [VAL_W-1:0]  r_q, r_d;
  logic [VAL_W-1:0]  q_q;
  logic [DCW-1:0]    cnt_q;
  status_e           status_q;
  logic              out_valid_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [VAL_W-1:0]  out_count_q;
  status_e           out_status_q;
  logic              out_last_q;

  logic [VAL_W-1:0]  denom_cur;
  logic [VAL_W:0]    r_sh;
  logic              r_ge;
  logic              commit;

  assign ix        = idx_q[IW-1:0];
  assign denom_cur = denoms_i[ix];
  assign r_sh      = {r_q, q_q[VAL_W-1]};
  assign r_ge      = r_sh >= {1'b0, denom_cur};
  assign r_d       = r_ge ? VAL_W'(r_sh - {1'b0, denom_cur}) : r_sh[VAL_W-1:0];
  assign commit    = use_stock_i && (status_q == ST_EXACT);

  always_comb begin
    stat_o.walk_done  = (SLOT_W'(idx_q) == n_i) || (rem_q == '0);
    stat_o.denom_zero = denom_cur == '0;
    stat_o.div_last   = cnt_q == DCW'(VAL_W - 1);
    stat_o.over_stock = use_stock_i && (q_q > stock_q[ix]);
    stat_o.emit_last  = SLOT_W'(idx_q) == (n_i - SLOT_W'(1));
    stat_o.out_free   = !out_valid_q || m_ready_i;
  end

  // coin stock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_DENOMS; k++) stock_q[k] <= '0;
    end else begin
      priority if (cmd_i.restock) begin
        for (int k = 0; k < NUM_DENOMS; k++) begin
          stock_q[k] <= (stock_q[k] > ('1 - RESTOCK_STEP)) ? '1 : stock_q[k] + RESTOCK_STEP;
        end
      end else if (cmd_i.set_stock) begin
        if (sel_i < NMAX) stock_q[sel_i[IW-1:0]] <= sval_i;
      end else if (cmd_i.emit && commit) begin
        stock_q[ix] <= stock_q[ix] - counts_q[ix];
      end else begin
      end
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (cmd_i.start || cmd_i.finish || (cmd_i.check && stat_o.over_stock)) begin
        idx_q <= '0;
      end else if (cmd_i.skip || cmd_i.check || cmd_i.emit) begin
        idx_q <= idx_q + CW'(1);
      end else begin
      end
      if (cmd_i.div_start) cnt_q <= '0;
      else if (cmd_i.div_step) cnt_q <= cnt_q + DCW'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  // walk and divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q    <= amount_i;
      status_q <= ST_EXACT;
      for (int k = 0; k < NUM_DENOMS; k++) counts_q[k] <= '0;
    end
    if (cmd_i.div_start) begin
      r_q <= '0;
      q_q <= rem_q;
    end
    if (cmd_i.div_step) begin
      r_q <= r_d;
      q_q <= {q_q[VAL_W-2:0], r_ge};
    end
    if (cmd_i.check) begin
      if (stat_o.over_stock) begin
        status_q <= ST_NO_STOCK;
      end else begin
        counts_q[ix] <= q_q;
        rem_q        <= r_q;
      end
    end
    if (cmd_i.finish) status_q <= (rem_q != '0) ? ST_NO_EXACT : ST_EXACT;
    if (cmd_i.emit) begin
      out_slot_q   <= SLOT_W'(idx_q);
      out_count_q  <= (status_q == ST_EXACT) ? counts_q[ix] : '0;
      out_status_q <= status_q;
      out_last_q   <= stat_o.emit_last;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_slot_o   = out_slot_q;
  assign m_count_o  = out_count_q;
  assign m_status_o = out_status_q;
  assign m_last_o   = out_last_q;

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check |-> (r_q < denom_cur))
    else $error("divider remainder not below denomination");

  a_fail_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.check && stat_o.over_stock) |=> (status_q == ST_NO_STOCK))
    else $error("stock failure not recorded");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && commit) |-> (counts_q[ix] <= stock_q[ix]))
    else $error("stock consumption underflows");

  a_exact_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (status_q == ST_EXACT)) |-> (rem_q == '0))
    else $error("exact status with nonzero remainder");

endmodule
`default_nettype wire

// ----- rtl/greedy_coin_change_with_stock_top.sv -----
// greedy change maker with per-denomination coin stock
// input stream s_axis: tuser carries the opcode (change, restock, set stock, none),
// tdata carries amount, slot_select and stock_value. a change request returns one
// word per denomination in use on m_axis: tdata holds slot and coin count, tuser
// the status, tlast marks the last denomination. restock and set requests return
// nothing.
// configuration over apb: use_stock, num_denoms, denom_0..denom_5 at 4*i, pready high.
// a change request walks the denominations in order; each one takes a setup step,
// a bit-serial restoring divider and a stock check, and a zero denomination is
// skipped. then one word per denomination leaves through the output register.
// one request is worked on at a time; tready is high only between requests.
// the output register holds its word while m_axis_tready is low and the emit
// phase pauses; the next request is taken while the final word still waits.
// reset clears the stock to zero and loads the default configuration
// (stock off, six denominations 200, 100, 50, 20, 10, 5).
`default_nettype none
module greedy_coin_change_with_stock_top #(
  parameter int NUM_DENOMS = gccs_pkg::NUM_DENOMS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // amount[15:0], slot_select[18:16], stock_value[34:19], zero fill
  input  wire logic [gccs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // opcode[1:0]
  input  wire logic [gccs_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // slot[2:0], coin_count[18:3], zero fill
  output logic [gccs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // status[1:0]
  output logic [gccs_pkg::ST_W-1:0]               m_axis_tuser,
  output logic                                    m_axis_tlast,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gccs_pkg::CFG_AW-1:0]        paddr,
  input  wire logic [gccs_pkg::CFG_DW-1:0]        pwdata,
  output logic [gccs_pkg::CFG_DW-1:0]             prdata,
  output logic                                    pready
);
  import gccs_pkg::*;

  localparam logic [SLOT_W-1:0] NMAX = SLOT_W'(NUM_DENOMS);

  logic                                  use_stock_q;
  logic [SLOT_W-1:0]                     num_denoms_q;
  logic [DENOM_REGS-1:0][VAL_W-1:0]      denom_q;
  logic [SLOT_W-1:0]                     n_eff;
  reg_e                                  reg_sel;
  cmd_t                                  cmd;
  stat_t                                 stat;
  logic [SLOT_W-1:0]                     out_slot;
  logic [VAL_W-1:0]                      out_count;

  assign reg_sel = reg_e'(paddr[CFG_AW-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_stock_q  <= 1'b0;
      num_denoms_q <= SLOT_W'(DENOM_REGS);
      denom_q      <= DENOM_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_USE_STOCK:  use_stock_q  <= pwdata[0];
        REG_NUM_DENOMS: num_denoms_q <= pwdata[SLOT_W-1:0];
        REG_DENOM_0:    denom_q[0]   <= pwdata[VAL_W-1:0];
        REG_DENOM_1:    denom_q[1]   <= pwdata[VAL_W-1:0];
        REG_DENOM_2:    denom_q[2]   <= pwdata[VAL_W-1:0];
        REG_DENOM_3:    denom_q[3]   <= pwdata[VAL_W-1:0];
        REG_DENOM_4:    denom_q[4]   <= pwdata[VAL_W-1:0];
        REG_DENOM_5:    denom_q[5]   <= pwdata[VAL_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_USE_STOCK:  prdata = CFG_DW'(use_stock_q);
      REG_NUM_DENOMS: prdata = CFG_DW'(num_denoms_q);
      REG_DENOM_0:    prdata = CFG_DW'(denom_q[0]);
      REG_DENOM_1:    prdata = CFG_DW'(denom_q[1]);
      REG_DENOM_2:    prdata = CFG_DW'(denom_q[2]);
      REG_DENOM_3:    prdata = CFG_DW'(denom_q[3]);
      REG_DENOM_4:    prdata = CFG_DW'(denom_q[4]);
      REG_DENOM_5:    prdata = CFG_DW'(denom_q[5]);
      default:        prdata = '0;
    endcase
  end

  // zero acts as one, above the build size acts as the build size
  always_comb begin
    priority if (num_denoms_q == '0) n_eff = SLOT_W'(1);
    else if (num_denoms_q > NMAX)    n_eff = NMAX;
    else                             n_eff = num_denoms_q;
  end

  gccs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .opcode_i  (opcode_e'(s_axis_tuser)),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  gccs_dp #(
    .NUM_DENOMS (NUM_DENOMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .use_stock_i (use_stock_q),
    .n_i         (n_eff),
    .denoms_i    (denom_q[NUM_DENOMS-1:0]),
    .amount_i    (s_axis_tdata[VAL_W-1:0]),
    .sel_i       (s_axis_tdata[VAL_W+SLOT_W-1:VAL_W]),
    .sval_i      (s_axis_tdata[2*VAL_W+SLOT_W-1:VAL_W+SLOT_W]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_slot_o    (out_slot),
    .m_count_o   (out_count),
    .m_status_o  (m_axis_tuser),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - VAL_W - SLOT_W)'(0), out_count, out_slot};

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import gccs_pkg::*;

  localparam int SLOTS        = NUM_DENOMS_DEF;
  localparam int DRAIN_TAIL   = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  coin_count;
    status_e           status;
    logic              last;
  } change_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]        m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [CFG_AW-1:0]      paddr   = '0;
  logic [CFG_DW-1:0]      pwdata  = '0;
  logic [CFG_DW-1:0]      prdata;
  logic                   pready;

  // predictor state
  logic                 use_stock_m;
  logic [2:0]           num_denoms_m;
  logic [VAL_W-1:0]     denom_m [SLOTS];
  logic [VAL_W-1:0]     coin_stock_m [SLOTS];
  change_word_t         expected_words [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on     = 1'b1;
  bit          stalls_on   = 1'b1;
  int unsigned hold_reqs   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  greedy_coin_change_with_stock_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** greedy_coin_change_with_stock_top: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !stalls_on || ($urandom_range(99) >= 14);
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
               what, cycle_count, got, want);
  endtask

  always @(posedge clk_i) begin : check_words
    change_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, slot", m_axis_tdata[2:0], 0);
      end else begin
        want = expected_words.pop_front();
        if (m_axis_tdata[2:0] !== want.slot)
          report_mismatch("slot", m_axis_tdata[2:0], want.slot);
        if (m_axis_tdata[18:3] !== want.coin_count)
          report_mismatch("coin_count", m_axis_tdata[18:3], want.coin_count);
        if (m_axis_tuser !== want.status)
          report_mismatch("status", m_axis_tuser, want.status);
        if (m_axis_tlast !== want.last)
          report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  task automatic apply_request(opcode_e op, logic [VAL_W-1:0] amount,
                               logic [SLOT_W-1:0] sel, logic [VAL_W-1:0] sval);
    int unsigned     n;
    int unsigned     rem;
    int unsigned     cnt;
    int unsigned     sum;
    logic [VAL_W-1:0] counts [SLOTS];
    status_e         st;
    change_word_t    w;
    case (op)
      OP_RESTOCK: begin
        for (int i = 0; i < SLOTS; i++) begin
          sum = 32'(coin_stock_m[i]) + 32'(RESTOCK_STEP);
          coin_stock_m[i] = (sum > 32'hffff) ? 16'hffff : sum[VAL_W-1:0];
        end
      end
      OP_SET: begin
        if (sel < SLOTS) coin_stock_m[sel] = sval;
      end
      OP_CHANGE: begin
        n = (num_denoms_m == 0) ? 1 : ((num_denoms_m > SLOTS) ? SLOTS : num_denoms_m);
        rem = 32'(amount);
        st = ST_EXACT;
        for (int i = 0; i < SLOTS; i++) counts[i] = '0;
        for (int i = 0; i < n && rem != 0 && st == ST_EXACT; i++) begin
          cnt = (denom_m[i] != 0) ? rem / 32'(denom_m[i]) : 0;
          if (use_stock_m && cnt > 32'(coin_stock_m[i])) begin
            st = ST_NO_STOCK;
          end else begin
            counts[i] = cnt[VAL_W-1:0];
            rem = rem - cnt * 32'(denom_m[i]);
          end
        end
        if (st == ST_EXACT && rem != 0) st = ST_NO_EXACT;
        for (int i = 0; i < n; i++) begin
          if (st != ST_EXACT) counts[i] = '0;
          else if (use_stock_m) coin_stock_m[i] = coin_stock_m[i] - counts[i];
          w.slot       = i[SLOT_W-1:0];
          w.coin_count = counts[i];
          w.status     = st;
          w.last       = (i + 1 == n);
          expected_words.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_word(opcode_e op, logic [VAL_W-1:0] amount,
                           logic [SLOT_W-1:0] sel, logic [VAL_W-1:0] sval);
    if (gaps_on) begin
      while ($urandom_range(99) < 14) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, sval, sel, amount};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(op, amount, sel, sval);
  endtask

  task automatic send_random();
    opcode_e          op;
    logic [VAL_W-1:0] amount;
    logic [VAL_W-1:0] sval;
    logic [SLOT_W-1:0] sel;
    int unsigned      pick;
    pick   = $urandom_range(99);
    amount = VAL_W'($urandom_range(65535));
    sel    = SLOT_W'($urandom_range(7));
    sval   = VAL_W'($urandom_range(65535));
    if (pick < 62) begin
      op = OP_CHANGE;
      if ($urandom_range(1) == 1) amount = VAL_W'($urandom_range(1000));
    end else if (pick < 78) begin
      op = OP_SET;
      if ($urandom_range(2) != 0) sval = VAL_W'($urandom_range(60));
    end else if (pick < 93) begin
      op = OP_RESTOCK;
    end else begin
      op = OP_NONE;
    end
    send_word(op, amount, sel, sval);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_e r, logic [CFG_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_USE_STOCK:  use_stock_m  = v[0];
      REG_NUM_DENOMS: num_denoms_m = v[2:0];
      default:        denom_m[r - REG_DENOM_0] = v[VAL_W-1:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_random_config(bit stock_mode, logic [2:0] count);
    logic [VAL_W-1:0] d;
    bit               sorted;
    sorted = ($urandom_range(3) != 0);
    cfg_write(REG_USE_STOCK, CFG_DW'(stock_mode));
    cfg_write(REG_NUM_DENOMS, CFG_DW'(count));
    d = VAL_W'($urandom_range(900, 40));
    for (int i = 0; i < SLOTS; i++) begin
      if (!sorted)
        d = ($urandom_range(3) == 0) ? VAL_W'($urandom_range(65535))
                                     : VAL_W'($urandom_range(300));
      else if (i != 0)
        d = VAL_W'($urandom_range(d, 1));
      cfg_write(reg_e'(REG_DENOM_0 + i), CFG_DW'(d));
    end
  endtask

  task automatic test_basic_requests();
    send_word(OP_CHANGE, 16'd0, 3'd0, 16'd0);
    send_word(OP_CHANGE, 16'hffff, 3'd7, 16'hffff);
    send_word(OP_CHANGE, 16'd3, 3'd0, 16'd0);
    send_word(OP_NONE, 16'hffff, 3'd7, 16'hffff);
    send_word(OP_SET, 16'd0, 3'd7, 16'hffff);
    send_word(OP_SET, 16'd0, 3'd6, 16'd100);
    wait_idle();
  endtask

  task automatic test_stock_limits();
    cfg_write(REG_USE_STOCK, 1);
    send_word(OP_CHANGE, 16'd385, 3'd0, 16'd0);
    send_word(OP_RESTOCK, 16'd0, 3'd0, 16'd0);
    send_word(OP_CHANGE, 16'd385, 3'd0, 16'd0);
    send_word(OP_CHANGE, 16'd2000, 3'd0, 16'd0);
    send_word(OP_SET, 16'd0, 3'd0, 16'd65530);
    send_word(OP_RESTOCK, 16'd0, 3'd0, 16'd0);
    send_word(OP_CHANGE, 16'hffff, 3'd0, 16'd0);
    send_word(OP_SET, 16'd0, 3'd5, 16'd0);
    send_word(OP_CHANGE, 16'd5, 3'd0, 16'd0);
    wait_idle();
  endtask

  task automatic test_denom_corners();
    cfg_write(REG_USE_STOCK, 0);
    cfg_write(REG_NUM_DENOMS, 0);
    send_word(OP_CHANGE, 16'd450, 3'd0, 16'd0);
    wait_idle();
    // unsorted, with a zero denomination
    cfg_write(REG_NUM_DENOMS, 7);
    cfg_write(REG_DENOM_0, 7);
    cfg_write(REG_DENOM_1, 0);
    cfg_write(REG_DENOM_2, 32'h0000_ffff);
    cfg_write(REG_DENOM_3, 1);
    cfg_write(REG_DENOM_4, 3);
    cfg_write(REG_DENOM_5, 2);
    send_word(OP_CHANGE, 16'hffff, 3'd0, 16'd0);
    send_word(OP_CHANGE, 16'd6, 3'd0, 16'd0);
    wait_idle();
    cfg_write(REG_NUM_DENOMS, 3);
    send_word(OP_CHANGE, 16'd8, 3'd0, 16'd0);
    wait_idle();
    cfg_write(REG_NUM_DENOMS, 1);
    cfg_write(REG_DENOM_0, 1);
    send_word(OP_CHANGE, 16'hffff, 3'd0, 16'd0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [2:0] count;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: count = 3'd6;
        1: count = 3'd7;
        2: count = 3'd0;
        3: count = 3'd1;
        default: count = 3'($urandom_range(7));
      endcase
      program_random_config((phase % 2) == 1, count);
      for (int k = 0; k < 64; k++) begin
        send_random();
        if ($urandom_range(99) < 3) wait_idle();
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    program_random_config(1'b0, 3'd6);
    hold_reqs++;
    for (int k = 0; k < 24; k++)
      send_word(OP_CHANGE, VAL_W'($urandom_range(2000)), SLOT_W'($urandom_range(7)),
                VAL_W'($urandom_range(65535)));
    wait_idle();
  endtask

  task automatic test_full_rate();
    program_random_config(1'b1, 3'($urandom_range(7)));
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int k = 0; k < 50; k++) send_random();
    wait_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    use_stock_m  = 1'b0;
    num_denoms_m = 3'd6;
    for (int i = 0; i < SLOTS; i++) begin
      denom_m[i]      = DENOM_RST[i];
      coin_stock_m[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_requests();
    test_stock_limits();
    test_denom_corners();
    test_random_traffic();
    test_backpressure();
    test_full_rate();

    wait_idle();
    if (error_count == 0) begin
      $display("** greedy_coin_change_with_stock_top: PASSED **");
    end else begin
      $display("** greedy_coin_change_with_stock_top: FAILED **");
    end
    $finish;
  end

endmodule
